FILE: design/bpm_pkg.sv
// Shared constants, types and record layout for the bracket pair matcher.
package bpm_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int OFFSET_BITS = 20;

  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  // Output tdata: open_offset, close_offset, status, error_offset, padded to bytes
  localparam int OUT_W       = 3 * OFFSET_BITS + 3;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef enum logic [1:0] {
    KIND_PAREN  = 2'd0,
    KIND_BRACE  = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_STRAY_PAREN = 3'd1,
    ST_STRAY_BRACE = 3'd2,
    ST_OPEN_PAREN  = 3'd3,
    ST_OPEN_BRACE  = 3'd4,
    ST_CAPACITY    = 3'd5
  } stat_t;

  typedef struct packed {
    kind_t                  kind;
    logic [OFFSET_BITS-1:0] open_ofs;
    logic [OFFSET_BITS-1:0] close_ofs;
    stat_t                  status;
    logic [OFFSET_BITS-1:0] err_ofs;
    logic                   last;
  } rec_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } stack_ctl_t;

endpackage

FILE: design/bpm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/bpm_stack.sv
// Offset stack: top entry in a register, entry below it prefetched from RAM.
module bpm_stack import bpm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  stack_ctl_t             ctl,
  input  logic [OFFSET_BITS-1:0] push_data,
  output logic [OFFSET_BITS-1:0] top,
  output logic [OFFSET_BITS-1:0] below,
  output logic [CNT_W-1:0]       count
);

  logic [CNT_W-1:0]       count_next;
  logic [CNT_W-1:0]       rd_index;
  logic [OFFSET_BITS-1:0] top_next;

  always_comb begin
    priority if (ctl.clear) begin
      count_next = '0;
    end else if (ctl.push) begin
      count_next = count + CNT_W'(1);
    end else if (ctl.pop) begin
      count_next = count - CNT_W'(1);
    end else begin
      count_next = count;
    end
    // next cycle the RAM shows the entry just below the new top
    rd_index = count_next - CNT_W'(2);
    priority if (ctl.push) begin
      top_next = push_data;
    end else if (ctl.pop) begin
      top_next = below;
    end else begin
      top_next = top;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
    top <= top_next;
  end

  bpm_ram #(
    .WIDTH(OFFSET_BITS),
    .DEPTH(STACK_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ctl.push),
    .waddr(count[ADDR_W-1:0]),
    .wdata(push_data),
    .raddr(rd_index[ADDR_W-1:0]),
    .rdata(below)
  );

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    ctl.push |-> count != CNT_W'(STACK_DEPTH))
    else $error("push on full stack");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    ctl.pop |-> count != '0)
    else $error("pop on empty stack");
  a_push_top: assert property (@(posedge clk) disable iff (rst)
    ctl.push |=> top == $past(push_data))
    else $error("top register missed a push");
  // popping the last entry leaves no valid entry below, so only deeper pops are checked
  a_pop_top: assert property (@(posedge clk) disable iff (rst)
    (ctl.pop && !ctl.push && count > CNT_W'(1)) |=> top == $past(below))
    else $error("top register missed the prefetched entry on pop");
`endif

endmodule

FILE: design/bpm_result_queue.sv
// Three-entry result queue; takes up to two records per cycle while room is high, drains one.
module bpm_result_queue import bpm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] wr_valid,
  input  rec_t       wr_rec [2],
  output logic       room,
  output logic       head_valid,
  output rec_t       head,
  input  logic       head_ready
);

  localparam int QD = 3;

  rec_t       q      [QD];
  rec_t       q_next [QD];
  logic [1:0] qn;
  logic [1:0] qn_next;
  logic [1:0] base;
  logic       pop;

  always_comb begin
    pop  = head_valid & head_ready;
    base = qn - 2'(pop);
    for (int i = 0; i < QD; i++) begin
      if (pop && i < QD - 1) begin
        q_next[i] = q[i + 1];
      end else begin
        q_next[i] = q[i];
      end
      if (wr_valid[0] && 2'(i) == base) begin
        q_next[i] = wr_rec[0];
      end
      if (wr_valid[1] && 2'(i) == base + 2'd1) begin
        q_next[i] = wr_rec[1];
      end
    end
    qn_next = base + 2'(wr_valid[0]) + 2'(wr_valid[1]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      qn <= '0;
    end else begin
      qn <= qn_next;
    end
    q <= q_next;
  end

  assign head_valid = (qn != 2'd0);
  assign head       = q[0];
  assign room       = (qn <= 2'd1);

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (|wr_valid) |-> qn <= 2'd1)
    else $error("result queue written without room for two records");
  a_compact: assert property (@(posedge clk) disable iff (rst)
    wr_valid[1] |-> wr_valid[0])
    else $error("second record written without the first");
  a_grow: assert property (@(posedge clk) disable iff (rst)
    (wr_valid[0] && !pop) |=> qn == $past(qn) + 2'd1 + 2'($past(wr_valid[1])))
    else $error("queue fill count lost a record");
`endif

endmodule

FILE: design/bracket_pair_matcher_core.sv
// Top level of the bracket pair matcher: offset counter, error tracking, record build.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+---------------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | tdata=char_code, tuser=char_present,
//          |     |                    | tlast=end_of_source
//  m_      | out | m_tvalid/m_tready  | tdata=open,close,status,error offsets,
//          |     |                    | tuser=record_kind, tlast=last_result
//
//  One item per cycle while s_tready is high: each stack keeps its top in a register
//  and the RAM always presents the entry below it, so a push or pop never stalls the input.
//  An item gives zero, one or two records; they enter a three-entry queue, and
//  s_tready is high while at most one record waits, so a stalled m_ side still
//  lets one more item in. Items that give two records (closer plus end marker)
//  hold s_tready low until at most one record waits again.
//  Reset (rst, synchronous) clears stack counts, offset, error flag and the
//  queue; stack RAM contents are left as they are and are never read unwritten.
module bracket_pair_matcher_core import bpm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [7:0]             s_tdata,   // [7:0] char_code
  input  logic                   s_tuser,   // [0] char_present
  input  logic                   s_tlast,   // end_of_source
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // open_offset, close_offset, status,
                                            // error_offset, zero pad
  output logic [1:0]             m_tuser,   // [1:0] record_kind
  output logic                   m_tlast    // last_result
);

  logic [OFFSET_BITS:0]   offset;      // next byte offset, top bit flags overflow
  logic [OFFSET_BITS:0]   offset_next;
  logic                   failed;
  logic                   failed_next;

  logic                   xfer, act, go, ovf, ending;
  logic                   is_lp, is_rp, is_lb, is_rb;
  logic                   p_full, p_empty, b_full, b_empty;
  logic [OFFSET_BITS-1:0] pos;
  logic [OFFSET_BITS-1:0] p_top, p_below, b_top, b_below;
  logic [CNT_W-1:0]       p_count, b_count, p_after, b_after;
  stack_ctl_t             p_ctl, b_ctl;
  rec_t                   rec0, rec1;
  logic                   rec0_v, rec1_v, new_fail;
  logic [1:0]             wr_valid;
  rec_t                   wr_rec [2];
  logic                   q_room;
  rec_t                   head;

  always_comb begin
    xfer    = s_tvalid & s_tready;
    ending  = s_tlast;
    act     = xfer & s_tuser & !failed;
    ovf     = offset[OFFSET_BITS];
    go      = act & !ovf;
    pos     = offset[OFFSET_BITS-1:0];
    is_lp   = (s_tdata == CH_LPAREN);
    is_rp   = (s_tdata == CH_RPAREN);
    is_lb   = (s_tdata == CH_LBRACE);
    is_rb   = (s_tdata == CH_RBRACE);
    p_full  = (p_count == CNT_W'(STACK_DEPTH));
    b_full  = (b_count == CNT_W'(STACK_DEPTH));
    p_empty = (p_count == '0);
    b_empty = (b_count == '0);

    p_ctl.push  = go & is_lp & !p_full;
    p_ctl.pop   = go & is_rp & !p_empty;
    p_ctl.clear = xfer & ending;
    b_ctl.push  = go & is_lb & !b_full;
    b_ctl.pop   = go & is_rb & !b_empty;
    b_ctl.clear = xfer & ending;

    // record caused by the byte itself: a pair or an error
    rec0        = '0;
    rec0.kind   = KIND_STATUS;
    rec0.status = ST_OK;
    rec0_v      = 1'b0;
    new_fail    = 1'b0;
    if (act) begin
      priority if (ovf) begin
        rec0_v      = 1'b1;
        new_fail    = 1'b1;
        rec0.status = ST_CAPACITY;
        rec0.err_ofs = '1;
      end else if ((is_lp && p_full) || (is_lb && b_full)) begin
        rec0_v       = 1'b1;
        new_fail     = 1'b1;
        rec0.status  = ST_CAPACITY;
        rec0.err_ofs = pos;
      end else if (is_rp) begin
        rec0_v = 1'b1;
        if (p_empty) begin
          new_fail     = 1'b1;
          rec0.status  = ST_STRAY_PAREN;
          rec0.err_ofs = pos;
        end else begin
          rec0.kind      = KIND_PAREN;
          rec0.open_ofs  = p_top;
          rec0.close_ofs = pos;
        end
      end else if (is_rb) begin
        rec0_v = 1'b1;
        if (b_empty) begin
          new_fail     = 1'b1;
          rec0.status  = ST_STRAY_BRACE;
          rec0.err_ofs = pos;
        end else begin
          rec0.kind      = KIND_BRACE;
          rec0.open_ofs  = b_top;
          rec0.close_ofs = pos;
        end
      end else begin
        rec0_v = 1'b0;
      end
    end

    // end-of-source status, seen after this byte's push or pop
    p_after     = p_count + CNT_W'(p_ctl.push) - CNT_W'(p_ctl.pop);
    b_after     = b_count + CNT_W'(b_ctl.push) - CNT_W'(b_ctl.pop);
    rec1        = '0;
    rec1.kind   = KIND_STATUS;
    rec1.status = ST_OK;
    if (p_after != '0) begin
      rec1.status  = ST_OPEN_PAREN;
      rec1.err_ofs = p_ctl.push ? pos : (p_ctl.pop ? p_below : p_top);
    end else if (b_after != '0) begin
      rec1.status  = ST_OPEN_BRACE;
      rec1.err_ofs = b_ctl.push ? pos : (b_ctl.pop ? b_below : b_top);
    end
    rec1_v    = xfer & ending & !failed & !new_fail;
    rec0.last = !rec1_v;
    rec1.last = 1'b1;

    // compact so the queue always sees its first slot filled first
    wr_valid  = {rec0_v & rec1_v, rec0_v | rec1_v};
    wr_rec[0] = rec0_v ? rec0 : rec1;
    wr_rec[1] = rec1;

    // advance the offset on every counted byte, drop all state at the end marker
    if (xfer && ending) begin
      offset_next = '0;
      failed_next = 1'b0;
    end else begin
      offset_next = go ? offset + (OFFSET_BITS+1)'(1) : offset;
      failed_next = failed | new_fail;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset <= '0;
      failed <= 1'b0;
    end else begin
      offset <= offset_next;
      failed <= failed_next;
    end
  end

  bpm_stack u_paren (
    .clk      (clk),
    .rst      (rst),
    .ctl      (p_ctl),
    .push_data(pos),
    .top      (p_top),
    .below    (p_below),
    .count    (p_count)
  );

  bpm_stack u_brace (
    .clk      (clk),
    .rst      (rst),
    .ctl      (b_ctl),
    .push_data(pos),
    .top      (b_top),
    .below    (b_below),
    .count    (b_count)
  );

  bpm_result_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr_valid  (wr_valid),
    .wr_rec    (wr_rec),
    .room      (q_room),
    .head_valid(m_tvalid),
    .head      (head),
    .head_ready(m_tready)
  );

  // hold input while the queue could not take two more records
  assign s_tready = q_room;
  assign m_tdata  = OUT_TDATA_W'({head.err_ofs, head.status, head.close_ofs, head.open_ofs});
  assign m_tuser  = head.kind;
  assign m_tlast  = head.last;

endmodule

FILE: tb/sv/tb_bracket_pair_matcher_core.sv
// Self-checking testbench for the bracket pair matcher core with a built-in predictor.
module tb_bracket_pair_matcher_core;
  import bpm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Bit positions of the record fields inside m_tdata, lowest field first.
  localparam int OPEN_LSB  = 0;
  localparam int CLOSE_LSB = OFFSET_BITS;
  localparam int STAT_LSB  = 2 * OFFSET_BITS;
  localparam int ERR_LSB   = 2 * OFFSET_BITS + 3;

  // Hold the receiver off once, after this many records, for this many cycles.
  localparam int HOLD_AFTER  = 300;
  localparam int HOLD_CYCLES = 300;
  // Random bytes on top of about 800 directed items.
  localparam int RANDOM_ITEMS = 1000;

  typedef struct packed {
    logic [7:0] code;
    logic       present;
    logic       ending;
  } src_item_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [7:0]             s_tdata = 8'h00;
  logic                   s_tuser = 1'b0;
  logic                   s_tlast = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [1:0]             m_tuser;
  logic                   m_tlast;

  // Source bytes waiting for the driver, and records the block still owes us.
  src_item_t source_bytes[$];
  rec_t      pending_records[$];

  // Predictor state: one offset stack per bracket kind, next offset, error latch.
  logic [OFFSET_BITS-1:0] paren_ofs [STACK_DEPTH];
  logic [OFFSET_BITS-1:0] brace_ofs [STACK_DEPTH];
  int                     paren_depth = 0;
  int                     brace_depth = 0;
  logic [OFFSET_BITS:0]   next_ofs = '0;
  bit                     src_failed = 1'b0;

  // Traffic shaping and bookkeeping.
  bit idle_on = 1'b1;
  bit in_taken = 1'b0;
  int tx_burst = 0;
  int tx_gap = 0;
  int rx_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int fail_count = 0;
  int records_seen = 0;
  int pairs_seen = 0;
  int items_sent = 0;
  int sources_done = 0;

  bracket_pair_matcher_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // [7:0] char_code
    .s_tuser  (s_tuser),   // [0] char_present
    .s_tlast  (s_tlast),   // end_of_source
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // open_offset, close_offset, status, error_offset, zero pad
    .m_tuser  (m_tuser),   // [1:0] record_kind
    .m_tlast  (m_tlast)    // last_result
  );

  // 12 ns clock.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic rec_t status_rec(stat_t code, logic [OFFSET_BITS-1:0] where);
    rec_t r;
    r = '0;
    r.kind    = KIND_STATUS;
    r.status  = code;
    r.err_ofs = where;
    return r;
  endfunction

  function automatic rec_t pair_rec(kind_t kind, logic [OFFSET_BITS-1:0] opened,
                                    logic [OFFSET_BITS-1:0] closed);
    rec_t r;
    r = '0;
    r.kind      = kind;
    r.status    = ST_OK;
    r.open_ofs  = opened;
    r.close_ofs = closed;
    return r;
  endfunction

  // Advance the bracket matcher by one source item and queue the records it owes.
  task automatic match_brackets(logic [7:0] ch, logic present, logic ending);
    rec_t                 recs[2];
    int                   n;
    logic [OFFSET_BITS:0] pos;
    n = 0;
    if (present && !src_failed) begin
      pos = next_ofs;
      if (pos[OFFSET_BITS]) begin
        // Offset range used up: saturate the reported offset.
        recs[n] = status_rec(ST_CAPACITY, '1);
        n++;
        src_failed = 1'b1;
      end else begin
        next_ofs = pos + 1'b1;
        case (ch)
          CH_LPAREN: begin
            if (paren_depth >= STACK_DEPTH) begin
              recs[n] = status_rec(ST_CAPACITY, pos[OFFSET_BITS-1:0]);
              n++;
              src_failed = 1'b1;
            end else begin
              paren_ofs[paren_depth] = pos[OFFSET_BITS-1:0];
              paren_depth++;
            end
          end
          CH_LBRACE: begin
            if (brace_depth >= STACK_DEPTH) begin
              recs[n] = status_rec(ST_CAPACITY, pos[OFFSET_BITS-1:0]);
              n++;
              src_failed = 1'b1;
            end else begin
              brace_ofs[brace_depth] = pos[OFFSET_BITS-1:0];
              brace_depth++;
            end
          end
          CH_RPAREN: begin
            if (paren_depth == 0) begin
              recs[n] = status_rec(ST_STRAY_PAREN, pos[OFFSET_BITS-1:0]);
              n++;
              src_failed = 1'b1;
            end else begin
              paren_depth--;
              recs[n] = pair_rec(KIND_PAREN, paren_ofs[paren_depth], pos[OFFSET_BITS-1:0]);
              n++;
            end
          end
          CH_RBRACE: begin
            if (brace_depth == 0) begin
              recs[n] = status_rec(ST_STRAY_BRACE, pos[OFFSET_BITS-1:0]);
              n++;
              src_failed = 1'b1;
            end else begin
              brace_depth--;
              recs[n] = pair_rec(KIND_BRACE, brace_ofs[brace_depth], pos[OFFSET_BITS-1:0]);
              n++;
            end
          end
          default: ;
        endcase
      end
    end
    if (ending) begin
      // Open parens win over open braces; a failed source reports nothing more.
      if (!src_failed) begin
        if (paren_depth != 0)
          recs[n] = status_rec(ST_OPEN_PAREN, paren_ofs[paren_depth-1]);
        else if (brace_depth != 0)
          recs[n] = status_rec(ST_OPEN_BRACE, brace_ofs[brace_depth-1]);
        else
          recs[n] = status_rec(ST_OK, '0);
        n++;
      end
      paren_depth = 0;
      brace_depth = 0;
      next_ofs    = '0;
      src_failed  = 1'b0;
      sources_done++;
    end
    for (int i = 0; i < n; i++) begin
      recs[i].last = (i == n - 1);
      pending_records.insert(pending_records.size(), recs[i]);
    end
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Compare one output transfer against the oldest owed record.
  task automatic check_record();
    rec_t want;
    if (pending_records.size() == 0) begin
      $display("%0t: unexpected record: expected none, actual kind %0d tdata %h last %0d",
               $time, m_tuser, m_tdata, m_tlast);
      fail_count++;
    end else begin
      want = pending_records.pop_front();
      check_field("record_kind", want.kind, m_tuser);
      check_field("open_offset", want.open_ofs, m_tdata[OPEN_LSB +: OFFSET_BITS]);
      check_field("close_offset", want.close_ofs, m_tdata[CLOSE_LSB +: OFFSET_BITS]);
      check_field("status", want.status, m_tdata[STAT_LSB +: 3]);
      check_field("error_offset", want.err_ofs, m_tdata[ERR_LSB +: OFFSET_BITS]);
      check_field("zero pad", '0, 64'(m_tdata >> OUT_W));
      check_field("last_result", want.last, m_tlast);
      if (want.kind != KIND_STATUS)
        pairs_seen++;
    end
    records_seen++;
  endtask

  // Monitor: sample both handshakes at the rising edge. Predict first, then check.
  always @(posedge clk) begin
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) begin
        match_brackets(s_tdata, s_tuser, s_tlast);
        items_sent++;
      end
      if (m_tvalid && m_tready)
        check_record();
    end
  end

  // Driver: change inputs at the falling edge; hold the offered item until it is taken.
  always @(negedge clk) begin
    src_item_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      if (tx_gap > 0) begin
        tx_gap   <= tx_gap - 1;
        s_tvalid <= 1'b0;
      end else if (source_bytes.size() != 0) begin
        nxt = source_bytes.pop_front();
        s_tdata  <= nxt.code;
        s_tuser  <= nxt.present;
        s_tlast  <= nxt.ending;
        s_tvalid <= 1'b1;
        // End of burst: pick the next burst length and the gap after this item.
        if (tx_burst <= 1) begin
          tx_burst <= ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 16);
          tx_gap   <= idle_on ? $urandom_range(0, 5) : 0;
        end else begin
          tx_burst <= tx_burst - 1;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: its own ready/stall pattern, plus one long hold-off to back up the block.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && records_seen >= HOLD_AFTER) begin
      m_tready  <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (!idle_on) begin
      m_tready <= 1'b1;
    end else if (rx_left > 0) begin
      rx_left <= rx_left - 1;
    end else if (m_tready) begin
      m_tready <= 1'b0;
      rx_left  <= $urandom_range(0, 5);
    end else begin
      m_tready <= 1'b1;
      rx_left  <= ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 10);
    end
  end

  // Keep the driver queue short so long sources do not pile up in memory.
  task automatic queue_item(logic [7:0] code, logic present, logic ending);
    src_item_t it;
    while (source_bytes.size() >= 64)
      @(posedge clk);
    it.code    = code;
    it.present = present;
    it.ending  = ending;
    source_bytes.insert(source_bytes.size(), it);
  endtask

  task automatic queue_byte(logic [7:0] code, logic ending = 1'b0);
    queue_item(code, 1'b1, ending);
  endtask

  task automatic queue_bare_end();
    queue_item(8'($urandom), 1'b0, 1'b1);
  endtask

  function automatic logic [7:0] filler_byte();
    logic [7:0] ch;
    ch = 8'($urandom);
    if (ch == CH_LPAREN || ch == CH_RPAREN || ch == CH_LBRACE || ch == CH_RBRACE)
      ch = 8'h61;
    return ch;
  endfunction

  // One random source: mostly well nested with random text, some with stray brackets.
  task automatic add_random_source(output int bytes_made);
    src_item_t src[$];
    src_item_t it;
    int        len;
    int        roll;
    int        open_p;
    int        open_b;
    bit        noisy;
    bit        pick_paren;
    logic [7:0] ch;
    len    = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 24);
    noisy  = ($urandom_range(0, 7) == 0);
    open_p = 0;
    open_b = 0;
    bytes_made = 0;
    for (int i = 0; i < len; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        // Empty item: no byte, no end.
        it.code    = 8'($urandom);
        it.present = 1'b0;
        it.ending  = 1'b0;
        src.insert(src.size(), it);
        continue;
      end
      if (roll < 27) begin
        pick_paren = $urandom_range(0, 1);
        ch = pick_paren ? CH_LPAREN : CH_LBRACE;
        if (pick_paren) open_p++; else open_b++;
      end else if (roll < 47 && open_p + open_b > 0) begin
        pick_paren = (open_b == 0) || (open_p > 0 && $urandom_range(0, 1));
        ch = pick_paren ? CH_RPAREN : CH_RBRACE;
        if (pick_paren) open_p--; else open_b--;
      end else if (noisy && roll < 55) begin
        ch = $urandom_range(0, 1) ? CH_RPAREN : CH_RBRACE;
      end else begin
        ch = noisy ? 8'($urandom) : filler_byte();
      end
      it.code    = ch;
      it.present = 1'b1;
      it.ending  = 1'b0;
      src.insert(src.size(), it);
      bytes_made++;
    end
    // Usually close everything so the source ends clean; sometimes leave it open.
    if (!noisy && $urandom_range(0, 9) < 7) begin
      while (open_p + open_b > 0) begin
        pick_paren = (open_b == 0) || (open_p > 0 && $urandom_range(0, 1));
        ch = pick_paren ? CH_RPAREN : CH_RBRACE;
        if (pick_paren) open_p--; else open_b--;
        it.code    = ch;
        it.present = 1'b1;
        it.ending  = 1'b0;
        src.insert(src.size(), it);
        bytes_made++;
      end
    end
    // End either on the last byte or with a bare end marker.
    if (src.size() != 0 && src[$].present && $urandom_range(0, 1)) begin
      src[$].ending = 1'b1;
    end else begin
      it.code    = 8'($urandom);
      it.present = 1'b0;
      it.ending  = 1'b1;
      src.insert(src.size(), it);
    end
    foreach (src[i])
      queue_item(src[i].code, src[i].present, src[i].ending);
  endtask

  // Stimulus and end of run.
  initial begin
    int made;
    int random_bytes;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // Simple pair, then interleaved ({)} which is legal here.
    queue_byte(CH_LPAREN);
    queue_byte(CH_RPAREN);
    queue_bare_end();
    queue_byte(CH_LPAREN);
    queue_byte(CH_LBRACE);
    queue_byte(CH_RPAREN);
    queue_byte(CH_RBRACE);
    queue_bare_end();
    // Stray closer, then everything absorbed up to the end marker.
    queue_byte(CH_RPAREN);
    queue_byte(CH_LPAREN);
    queue_byte(CH_RBRACE, 1'b1);
    // Stray brace on the ending item: the error is the only record.
    queue_byte(CH_RBRACE, 1'b1);
    // Closer on the ending item: pair record plus open-brace status.
    queue_byte(8'h61);
    queue_byte(CH_LBRACE);
    queue_byte(CH_LPAREN);
    queue_byte(CH_RPAREN, 1'b1);
    // Opener on the ending item is pushed, then reported open.
    queue_byte(CH_LPAREN, 1'b1);
    // Empty items, byte extremes, two open parens: the top one is reported.
    queue_item(8'hFF, 1'b0, 1'b0);
    queue_item(8'h00, 1'b0, 1'b0);
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(CH_LPAREN);
    queue_byte(CH_LPAREN);
    queue_bare_end();
    queue_bare_end();

    // Full paren stack, reported open at its top.
    repeat (STACK_DEPTH) queue_byte(CH_LPAREN);
    queue_bare_end();
    // Full brace stack, one more opener on the ending item overflows it.
    repeat (STACK_DEPTH) queue_byte(CH_LBRACE);
    queue_byte(CH_LBRACE, 1'b1);
    // Full paren stack: pop, push back to full, then overflow.
    repeat (STACK_DEPTH) queue_byte(CH_LPAREN);
    queue_byte(CH_RPAREN);
    queue_byte(CH_LPAREN);
    queue_byte(CH_LPAREN);
    queue_bare_end();

    // Random sources.
    random_bytes = 0;
    while (random_bytes < RANDOM_ITEMS) begin
      add_random_source(made);
      random_bytes += made;
    end

    // Drain: all items taken, all records back, then a few quiet cycles.
    while (source_bytes.size() != 0 || s_tvalid || pending_records.size() != 0)
      @(negedge clk);
    repeat (20) @(negedge clk);
    $display("Sent %0d items over %0d sources; checked %0d records (%0d pairs).",
             items_sent, sources_done, records_seen, pairs_seen);
    $display("Covered stray closers, full stacks, mixed nesting and a long output stall.");
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // Watchdog: the whole run fits well inside 5 ms.
  initial begin
    #5_000_000;
    $display("Timeout with %0d records still owed.", pending_records.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: files.f
design/bpm_pkg.sv
design/bpm_ram.sv
design/bpm_stack.sv
design/bpm_result_queue.sv
design/bracket_pair_matcher_core.sv
tb/sv/tb_bracket_pair_matcher_core.sv
